[hdl/udp_flow_hash_histogram_defines.svh]
// Assertion macros for the UDP flow hash histogram checker.
// No dependencies; included by files that hold concurrent assertions.
`ifndef UDP_FLOW_HASH_HISTOGRAM_DEFINES_SVH
`define UDP_FLOW_HASH_HISTOGRAM_DEFINES_SVH

// Same-cycle implication.
`define UFH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("udp_flow_hash_histogram: same-cycle check failed");

// Next-cycle implication.
`define UFH_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("udp_flow_hash_histogram: next-cycle check failed");

`endif

[hdl/ufh_pkg.sv]
// Package for the UDP flow hash histogram: payload types, constants, hash step.
// No dependencies.
`default_nettype none

package ufh_pkg;

  localparam int unsigned NUM_BINS_DEF    = 1024 * 100;
  localparam int unsigned BIN_INDEX_W     = 17;
  localparam logic [31:0] JS_SEED         = 32'd1315423911;
  localparam logic [15:0] REPAIRED_LENGTH = 16'd1024;

  typedef struct packed {
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] ident_field;
    logic [15:0] ip_total_length;
    logic [15:0] udp_length;
  } ufh_in_t;

  typedef struct packed {
    logic [31:0]            new_source_address;
    logic [31:0]            new_dest_address;
    logic [15:0]            new_source_port;
    logic [15:0]            new_dest_port;
    logic [15:0]            fixed_total_length;
    logic                   header_valid;
    logic [31:0]            flow_hash;
    logic [BIN_INDEX_W-1:0] bin_index;
    logic [31:0]            bin_count;
  } ufh_out_t;

  typedef struct packed {
    logic [31:0] new_source_address;
    logic [31:0] new_dest_address;
    logic [15:0] new_source_port;
    logic [15:0] new_dest_port;
    logic [15:0] fixed_total_length;
    logic        header_valid;
  } ufh_meta_t;

  function automatic logic [31:0] js_step(input logic [31:0] h, input logic [7:0] b);
    return h ^ ((h << 5) + {24'd0, b} + (h >> 2));
  endfunction

endpackage

`default_nettype wire

[hdl/ufh_stream_if.sv]
// Valid/ready stream channel with a typed payload.
// No dependencies; the payload type comes in as a parameter.
`default_nettype none

interface ufh_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/ufh_bin_reduce.sv]
// Two-stage hash-to-bin reduction: reciprocal multiply, then one correction.
// Depends on ufh_pkg for the default bin count.
`default_nettype none

module ufh_bin_reduce #(
  parameter int unsigned NUM_BINS = ufh_pkg::NUM_BINS_DEF,
  parameter int unsigned AW       = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   hash,
  output logic [31:0]   hash_dly,
  output logic [AW-1:0] bin
);

  localparam int unsigned RW     = AW + 1;
  localparam logic [32:0] RECIP  = 33'((64'd1 << 32) / 64'(NUM_BINS));
  localparam logic [RW-1:0] BINS_R = RW'(NUM_BINS);

  logic [64:0]   prod;
  logic [31:0]   hash1;
  logic [31:0]   quot1;
  logic [RW-1:0] qn;
  logic [RW-1:0] rem;
  logic [RW-1:0] rem2;

  // quotient estimate is exact or one low, so the remainder stays below twice the bin count
  assign prod = 65'(hash) * 65'(RECIP);
  assign qn   = RW'(quot1 * 32'(NUM_BINS));
  assign rem  = RW'(hash1) - qn;

  always_ff @(posedge clk) begin
    if (en) begin
      hash1    <= hash;
      quot1    <= prod[63:32];
      hash_dly <= hash1;
      rem2     <= rem;
    end
  end

  assign bin = (rem2 >= BINS_R) ? AW'(rem2 - BINS_R) : AW'(rem2);

endmodule

`default_nettype wire

[hdl/udp_flow_hash_histogram.sv]
// UDP flow hash histogram. One packet header per cycle when not stalled; results leave
// one per cycle while the result side takes them. The rate is set by a single pipeline
// that advances as one whole: a stalled result stalls every stage and the header side.
// Bin counts live in one NUM_BINS x 32 memory, read one stage ahead of the write back,
// with the previous write forwarded when two headers in a row hit the same bin. After
// reset a clearing pass writes zero to every one of the NUM_BINS bins (102400 by
// default), one per cycle; no header is taken until it ends.
// Depends on ufh_pkg, ufh_stream_if and ufh_bin_reduce.
`default_nettype none

module udp_flow_hash_histogram #(
  parameter int unsigned NUM_BINS = ufh_pkg::NUM_BINS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ufh_stream_if.sink    hdr,
  ufh_stream_if.source  result
);

  import ufh_pkg::*;

  localparam int unsigned AW   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned LAST = 8;
  localparam logic [AW-1:0] CLR_LAST = AW'(NUM_BINS - 1);

  logic [31:0]   mem [NUM_BINS];

  logic          adv;
  logic          take;
  logic          clearing;
  logic [AW-1:0] clr_idx;
  logic [LAST:0] vld;

  ufh_meta_t     meta_next;
  ufh_meta_t     meta [LAST+1];
  logic [31:0]   pa_next;
  logic [31:0]   pp_next;
  logic [31:0]   pa0;
  logic [31:0]   pp0;
  logic [31:0]   s [1:4];
  logic [31:0]   h [2:5];

  logic [31:0]   hash7;
  logic [AW-1:0] bin7;
  logic [31:0]   hash8;
  logic [AW-1:0] bin8;
  logic [31:0]   rd8;
  logic [31:0]   cur8;
  logic [31:0]   cnt8;

  logic          last_v;
  logic [AW-1:0] last_bin;
  logic [31:0]   last_cnt;
  ufh_out_t      result_next;

  assign adv       = !result.valid || result.ready;
  assign hdr.ready = adv && !clearing;
  assign take      = hdr.valid && hdr.ready;

  always_comb begin
    meta_next.new_source_address = hdr.data.source_address + 32'd1;
    meta_next.new_dest_address   = hdr.data.dest_address + 32'd1;
    meta_next.new_source_port    = hdr.data.source_port + 16'd1;
    meta_next.new_dest_port      = hdr.data.dest_port + 16'd1;
    meta_next.fixed_total_length = (hdr.data.ip_total_length == '0) ?
                                   REPAIRED_LENGTH : hdr.data.ip_total_length;
    meta_next.header_valid = (hdr.data.ident_field != '0) &&
                             (meta_next.new_source_address != '0) &&
                             (meta_next.new_dest_address != '0) &&
                             (meta_next.new_source_port != '0) &&
                             (meta_next.new_dest_port != '0) &&
                             (hdr.data.udp_length != '0);
    pa_next = meta_next.new_source_address + meta_next.new_dest_address;
    pp_next = 32'(meta_next.new_source_port) + 32'(meta_next.new_dest_port);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta[0] <= meta_next;
      pa0     <= pa_next;
      pp0     <= pp_next;
      for (int i = 1; i <= LAST; i++) begin
        meta[i] <= meta[i-1];
      end
      s[1] <= pa0 + pp0;
      s[2] <= s[1];
      s[3] <= s[2];
      s[4] <= s[3];
      h[2] <= js_step(JS_SEED, s[1][7:0]);
      h[3] <= js_step(h[2], s[2][15:8]);
      h[4] <= js_step(h[3], s[3][23:16]);
      h[5] <= js_step(h[4], s[4][31:24]);
      hash8 <= hash7;
      bin8  <= bin7;
    end
  end

  ufh_bin_reduce #(
    .NUM_BINS (NUM_BINS),
    .AW       (AW)
  ) u_bin_reduce (
    .clk      (clk),
    .en       (adv),
    .hash     (h[5]),
    .hash_dly (hash7),
    .bin      (bin7)
  );

  // forward the write that lands on the same edge as this read
  assign cur8 = (last_v && last_bin == bin8) ? last_cnt : rd8;
  assign cnt8 = (cur8 == '1) ? cur8 : cur8 + 32'd1;

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= '0;
    end else if (adv && vld[LAST]) begin
      mem[bin8] <= cnt8;
    end
    if (adv) begin
      rd8 <= mem[bin7];
    end
  end

  always_comb begin
    result_next.new_source_address = meta[LAST].new_source_address;
    result_next.new_dest_address   = meta[LAST].new_dest_address;
    result_next.new_source_port    = meta[LAST].new_source_port;
    result_next.new_dest_port      = meta[LAST].new_dest_port;
    result_next.fixed_total_length = meta[LAST].fixed_total_length;
    result_next.header_valid       = meta[LAST].header_valid;
    result_next.flow_hash          = hash8;
    result_next.bin_index          = BIN_INDEX_W'(bin8);
    result_next.bin_count          = cnt8;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.data <= result_next;
      last_bin    <= bin8;
      last_cnt    <= cnt8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing     <= 1'b1;
      clr_idx      <= '0;
      vld          <= '0;
      last_v       <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + 1'b1;
        if (clr_idx == CLR_LAST) begin
          clearing <= 1'b0;
        end
      end
      if (adv) begin
        vld          <= {vld[LAST-1:0], take};
        last_v       <= vld[LAST];
        result.valid <= vld[LAST];
      end
    end
  end

endmodule

`default_nettype wire

[hdl/ufh_checker.sv]
// Port-level checks for udp_flow_hash_histogram, bound to the top level.
// Depends on ufh_pkg and udp_flow_hash_histogram_defines.svh.
`default_nettype none

`include "udp_flow_hash_histogram_defines.svh"

module ufh_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input ufh_pkg::ufh_out_t out_data
);

  logic fields_nonzero;
  logic result_nonzero;

  assign fields_nonzero = (out_data.new_source_address != '0) &&
                          (out_data.new_dest_address != '0) &&
                          (out_data.new_source_port != '0) &&
                          (out_data.new_dest_port != '0);
  assign result_nonzero = (out_data.bin_count != '0) && (out_data.fixed_total_length != '0);

  `UFH_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `UFH_ASSERT_NXT(a_clear_after_reset, clk, 1'b0, rst, !in_ready)
  `UFH_ASSERT_IMP(a_valid_fields, clk, rst, out_valid && out_data.header_valid, fields_nonzero)
  `UFH_ASSERT_IMP(a_count_nonzero, clk, rst, out_valid, result_nonzero)

endmodule

bind udp_flow_hash_histogram ufh_checker u_ufh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (hdr.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_data  (result.data)
);

`default_nettype wire
